// ===== rtl/gtr_pkg.sv =====
`default_nettype none

package gtr_pkg;

	localparam int SCREEN_WIDTH_DEF  = 240;
	localparam int SCREEN_HEIGHT_DEF = 160;
	localparam int GLYPH_ADVANCE_DEF = 7;

	localparam int GLYPH_COUNT = 27;
	localparam int GLYPH_ROWS  = 7;
	localparam int GLYPH_COLS  = 5;
	localparam int PEN_MAX     = 1023;

	localparam logic [14:0] COLOR_RESET = 15'h7FFF;
	localparam logic [7:0]  CASE_FOLD   = 8'd32;
	localparam logic [7:0]  CHAR_UP_A   = 8'h41;
	localparam logic [7:0]  CHAR_UP_Z   = 8'h5A;
	localparam logic [7:0]  CHAR_LO_A   = 8'h61;
	localparam logic [7:0]  CHAR_LO_Z   = 8'h7A;
	localparam logic [4:0]  GLYPH_BLANK = 5'd0;

	typedef logic [4:0] glyph_t;
	typedef logic [2:0] row_t;
	typedef logic [2:0] col_t;

	// Row-major glyphs; bit 4 of each row is the leftmost column.
	localparam logic [4:0] FONT_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
		'{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
		'{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E},
		'{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
		'{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
		'{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
		'{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
		'{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
		'{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
		'{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
		'{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
		'{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
		'{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h1F, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10, 5'h1F}
	};

	// Controller to datapath.
	typedef struct packed {
		logic load;     // take a new character, set up the scan
		logic step;     // advance to the next glyph bit
		logic capture;  // park the current pixel in the lookahead slot
		logic push;     // move the parked pixel to the output register
		logic last;     // pushed pixel closes the character
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic hit;       // current glyph bit is set and on screen
		logic scan_end;  // current bit is the last of the glyph
	} dp_status_t;

	// Fold lower case, map A..Z to 1..26, everything else to the blank glyph.
	function automatic glyph_t glyph_index(input logic [7:0] code);
		logic [7:0] up;
		up = code;
		if (code >= CHAR_LO_A && code <= CHAR_LO_Z) begin
			up = code - CASE_FOLD;
		end
		if (up >= CHAR_UP_A && up <= CHAR_UP_Z) begin
			return 5'(up - CHAR_UP_A) + 5'd1;
		end
		return GLYPH_BLANK;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gtr_char_if.sv =====
`default_nettype none

interface gtr_char_if;
	logic              valid;
	logic              ready;
	logic [7:0]        char_code;
	logic              first_of_string;
	logic signed [9:0] start_x;
	logic signed [8:0] start_y;

	modport source (
		output valid, char_code, first_of_string, start_x, start_y,
		input  ready
	);
	modport sink (
		input  valid, char_code, first_of_string, start_x, start_y,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/gtr_pix_if.sv =====
`default_nettype none

interface gtr_pix_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [14:0] pixel_color;
	logic        last_of_char;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, last_of_char,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, last_of_char,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/gtr_dp.sv =====
`default_nettype none

module gtr_dp #(
	parameter int SCREEN_WIDTH  = gtr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gtr_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_ADVANCE = gtr_pkg::GLYPH_ADVANCE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gtr_pkg::dp_cmd_t    cmd,
	output gtr_pkg::dp_status_t      status,
	input  wire logic [7:0]          char_code,
	input  wire logic                first_of_string,
	input  wire logic signed [9:0]   start_x,
	input  wire logic signed [8:0]   start_y,
	input  wire logic                color_we,
	input  wire logic [14:0]         color_wdata,
	output logic [7:0]               pixel_x,
	output logic [7:0]               pixel_y,
	output logic [14:0]              pixel_color,
	output logic                     last_of_char
);
	import gtr_pkg::*;

	logic signed [10:0] pen_q;
	logic signed [10:0] base_q;
	logic signed [8:0]  sy_q;
	glyph_t             glyph_q;
	row_t               row_q;
	col_t               col_q;
	logic [14:0]        color_q;
	logic [7:0]         pend_x_q;
	logic [7:0]         pend_y_q;
	logic [7:0]         out_x_q;
	logic [7:0]         out_y_q;
	logic               out_last_q;

	logic signed [10:0] base_d;
	logic signed [11:0] adv_sum;
	logic signed [11:0] px;
	logic signed [11:0] py;
	logic [4:0]         rom_row;
	logic [4:0]         rom_shift;
	logic               on_screen;

	always_comb begin
		base_d    = first_of_string ? 11'(start_x) : pen_q;
		adv_sum   = 12'(base_d) + 12'(GLYPH_ADVANCE);
		px        = 12'(base_q) + signed'({9'd0, col_q});
		py        = 12'(sy_q) + signed'({9'd0, row_q});
		rom_row   = FONT_ROM[glyph_q][row_q];
		rom_shift = rom_row << col_q;
		on_screen = !px[11] && (px < 12'(SCREEN_WIDTH))
			&& !py[11] && (py < 12'(SCREEN_HEIGHT));
		status.hit      = rom_shift[4] && on_screen;
		status.scan_end = (row_q == row_t'(GLYPH_ROWS - 1))
			&& (col_q == col_t'(GLYPH_COLS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q   <= '0;
			color_q <= COLOR_RESET;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			if (color_we) begin
				color_q <= color_wdata;
			end
			if (cmd.load) begin
				// Pen for the next character saturates at the right edge of its range.
				pen_q <= (adv_sum > 12'(PEN_MAX)) ? 11'(PEN_MAX) : 11'(adv_sum);
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.step) begin
				if (col_q == col_t'(GLYPH_COLS - 1)) begin
					col_q <= '0;
					row_q <= row_q + row_t'(1);
				end else begin
					col_q <= col_q + col_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= base_d;
			sy_q    <= start_y;
			glyph_q <= glyph_index(char_code);
		end
		if (cmd.capture) begin
			pend_x_q <= px[7:0];
			pend_y_q <= py[7:0];
		end
		if (cmd.push) begin
			out_x_q    <= pend_x_q;
			out_y_q    <= pend_y_q;
			out_last_q <= cmd.last;
		end
	end

	assign pixel_x      = out_x_q;
	assign pixel_y      = out_y_q;
	assign pixel_color  = color_q;
	assign last_of_char = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/gtr_ctrl.sv =====
`default_nettype none

module gtr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire gtr_pkg::dp_status_t status,
	output gtr_pkg::dp_cmd_t         cmd
);
	import gtr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pend_v_q;
	logic   pend_v_d;
	logic   out_v_q;
	logic   out_v_d;
	logic   out_free;

	assign out_free = !out_v_q || out_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		pend_v_d = pend_v_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				// Hold the scan when a new hit would need the busy output register.
				if (!(status.hit && pend_v_q && !out_free)) begin
					cmd.step = 1'b1;
					if (status.hit) begin
						cmd.capture = 1'b1;
						cmd.push    = pend_v_q;
						pend_v_d    = 1'b1;
					end
					if (status.scan_end) begin
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					cmd.push = 1'b1;
					cmd.last = 1'b1;
					pend_v_d = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		out_v_d = cmd.push || (out_v_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			pend_v_q <= pend_v_d;
			out_v_q  <= out_v_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_v_q;

`ifndef ASSERT_OFF
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("lookahead slot occupied while idle");

	a_push_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> out_free)
		else $error("pixel pushed over an unaccepted output");

	a_load_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_SCAN) && !pend_v_q)
		else $error("scan did not start cleanly after load");

	a_last_only_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |-> (state_q == S_FLUSH) && cmd.push)
		else $error("last pixel flag outside flush");
`endif

endmodule

`default_nettype wire

// ===== rtl/glyph_text_rasterizer.sv =====
// Text rasterizer: draws one 5x7 character per input item into a screen of
// SCREEN_WIDTH x SCREEN_HEIGHT pixels.
// Channels: char_in carries char_code, first_of_string, start_x, start_y;
// pix_out carries one pixel write (pixel_x, pixel_y, pixel_color,
// last_of_char) per set glyph bit that lands on screen, row-major order.
// Clipped bits and the blank glyph produce nothing; the pen still advances.
// text_color_we / text_color_wdata write the pixel colour; write it only
// while no character is in flight.
// Sequence: a character is accepted, its glyph is scanned through the font
// table one bit per cycle unless the scan holds, and the final pixel, if any,
// is flushed. One pixel is held back to learn whether it is the last of the
// character, so a pixel reaches pix_out the cycle after the next on-screen
// set bit is scanned, and the final pixel reaches it after the flush.
// Stall: the output register keeps its pixel until taken; the scan holds
// only when a new hit meets a full lookahead slot and an output not being taken.
// char_in.ready is high only between characters.
// Reset: pen column 0, colour 0x7FFF, no pixel pending, output empty.

`default_nettype none

module glyph_text_rasterizer #(
	parameter int SCREEN_WIDTH  = gtr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = gtr_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_ADVANCE = gtr_pkg::GLYPH_ADVANCE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	gtr_char_if.sink         char_in,
	gtr_pix_if.source        pix_out,
	input  wire logic        text_color_we,
	input  wire logic [14:0] text_color_wdata
);
	import gtr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer: owns the scan state, the lookahead slot and output valid.
	gtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (char_in.valid),
		.in_ready  (char_in.ready),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Pen, font lookup, clipping, pixel registers and colour register.
	gtr_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.GLYPH_ADVANCE (GLYPH_ADVANCE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.char_code       (char_in.char_code),
		.first_of_string (char_in.first_of_string),
		.start_x         (char_in.start_x),
		.start_y         (char_in.start_y),
		.color_we        (text_color_we),
		.color_wdata     (text_color_wdata),
		.pixel_x         (pix_out.pixel_x),
		.pixel_y         (pix_out.pixel_y),
		.pixel_color     (pix_out.pixel_color),
		.last_of_char    (pix_out.last_of_char)
	);

endmodule

`default_nettype wire

// ===== dv/glyph_text_rasterizer_tb.sv =====
module glyph_text_rasterizer_tb;

	localparam int SCREEN_W      = 240;
	localparam int SCREEN_H      = 160;
	localparam int PEN_STEP      = 7;
	localparam int PEN_CEILING   = 1023;
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [14:0] SHADE_AT_RESET = 15'h7FFF;
	localparam logic [7:0]  CH_UPPER_A     = 8'h41;
	localparam logic [7:0]  CH_UPPER_Z     = 8'h5A;
	localparam logic [7:0]  CH_LOWER_A     = 8'h61;
	localparam logic [7:0]  CH_LOWER_Z     = 8'h7A;
	localparam logic [7:0]  CASE_GAP       = 8'd32;

	// 5x7 letter shapes, blank first, then A..Z; bit 4 of a row is the left column.
	localparam logic [4:0] LETTER_SHAPES [27][7] = '{
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
		'{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
		'{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E},
		'{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
		'{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
		'{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
		'{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
		'{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
		'{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
		'{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
		'{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
		'{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
		'{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h1F, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10, 5'h1F}
	};

	typedef struct packed {
		logic [7:0]        code;
		logic              first;
		logic signed [9:0] sx;
		logic signed [8:0] sy;
	} char_item_t;

	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [14:0] shade;
		logic        last;
	} pixel_write_t;

	logic        clk;
	logic        arst_n;
	logic        text_color_we;
	logic [14:0] text_color_wdata;

	gtr_char_if char_bus ();
	gtr_pix_if  pix_bus ();

	glyph_text_rasterizer DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.char_in          (char_bus),
		.pix_out          (pix_bus),
		.text_color_we    (text_color_we),
		.text_color_wdata (text_color_wdata)
	);

	// Characters waiting to be sent, and pixel writes the block still owes us.
	char_item_t   pending_chars[$];
	pixel_write_t owed_pixels[$];

	// Our own copy of the block's state.
	logic signed [10:0] pen_col;
	logic [14:0]        pen_shade;

	int chars_queued;
	int chars_taken;
	int fails;
	int cycle_count;
	int send_gap;
	int take_stall;
	int stall_now;
	bit send_calm;
	bit take_calm;
	char_item_t next_char;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Fold lower case onto upper case; letters pick shapes 1..26, all else the blank.
	function automatic int shape_of(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			c = c - CASE_GAP;
		end
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			return int'(c - CH_UPPER_A) + 1;
		end
		return 0;
	endfunction

	// Work out every on-screen pixel of one character, in scan order, and move the pen.
	task automatic rasterize_char(input logic [7:0] code, input logic first,
			input logic signed [9:0] sx, input logic signed [8:0] sy);
		pixel_write_t drawn[$];
		pixel_write_t w;
		int shape;
		int px;
		int py;
		int next_pen;
		if (first) begin
			pen_col = sx;
		end
		shape = shape_of(code);
		for (int row = 0; row < 7; row++) begin
			for (int col = 0; col < 5; col++) begin
				if (LETTER_SHAPES[shape][row][4 - col]) begin
					px = int'(pen_col) + col;
					py = int'(sy) + row;
					// drop anything off the 240x160 screen
					if (px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H) begin
						w.x     = 8'(px);
						w.y     = 8'(py);
						w.shade = pen_shade;
						w.last  = 1'b0;
						drawn.push_back(w);
					end
				end
			end
		end
		if (drawn.size() != 0) begin
			drawn[drawn.size() - 1].last = 1'b1;
		end
		foreach (drawn[i]) begin
			owed_pixels.push_back(drawn[i]);
		end
		// advance the pen, pinned at its ceiling
		next_pen = int'(pen_col) + PEN_STEP;
		if (next_pen > PEN_CEILING) begin
			next_pen = PEN_CEILING;
		end
		pen_col = 11'(next_pen);
	endtask

	task automatic compare_pixel();
		pixel_write_t want;
		if (owed_pixels.size() == 0) begin
			$error("pixel write with nothing owed: x %0d y %0d", pix_bus.pixel_x, pix_bus.pixel_y);
			fails++;
			return;
		end
		want = owed_pixels.pop_front();
		if (pix_bus.pixel_x !== want.x) begin
			$error("pixel_x: expected %0d, got %0d", want.x, pix_bus.pixel_x);
			fails++;
		end
		if (pix_bus.pixel_y !== want.y) begin
			$error("pixel_y: expected %0d, got %0d", want.y, pix_bus.pixel_y);
			fails++;
		end
		if (pix_bus.pixel_color !== want.shade) begin
			$error("pixel_color: expected %0h, got %0h", want.shade, pix_bus.pixel_color);
			fails++;
		end
		if (pix_bus.last_of_char !== want.last) begin
			$error("last_of_char: expected %0b, got %0b", want.last, pix_bus.last_of_char);
			fails++;
		end
	endtask

	// Character driver: hold each item until taken, then idle a drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bus.valid           <= 1'b0;
			char_bus.char_code       <= '0;
			char_bus.first_of_string <= 1'b0;
			char_bus.start_x         <= '0;
			char_bus.start_y         <= '0;
			send_gap                 <= 0;
		end else begin
			if (char_bus.valid && char_bus.ready) begin
				rasterize_char(char_bus.char_code, char_bus.first_of_string,
					char_bus.start_x, char_bus.start_y);
				chars_taken++;
			end
			if (!char_bus.valid || char_bus.ready) begin
				if (send_gap != 0) begin
					char_bus.valid <= 1'b0;
					send_gap       <= send_gap - 1;
				end else if (pending_chars.size() != 0) begin
					next_char = pending_chars.pop_front();
					char_bus.valid           <= 1'b1;
					char_bus.char_code       <= next_char.code;
					char_bus.first_of_string <= next_char.first;
					char_bus.start_x         <= next_char.sx;
					char_bus.start_y         <= next_char.sy;
					send_gap                 <= send_calm ? 0 : $urandom_range(0, 3);
				end else begin
					char_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor: check each item taken, then stall a drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_bus.ready <= 1'b0;
			take_stall    <= 0;
		end else begin
			stall_now = take_stall;
			if (pix_bus.valid && pix_bus.ready) begin
				compare_pixel();
				stall_now = take_calm ? 0 : $urandom_range(0, 3);
			end
			if (stall_now != 0) begin
				pix_bus.ready <= 1'b0;
				take_stall    <= stall_now - 1;
			end else begin
				pix_bus.ready <= 1'b1;
				take_stall    <= 0;
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_char(input logic [7:0] code, input logic first,
			input logic signed [9:0] sx, input logic signed [8:0] sy);
		char_item_t it;
		it.code  = code;
		it.first = first;
		it.sx    = sx;
		it.sy    = sy;
		pending_chars.push_back(it);
		chars_queued++;
	endtask

	// Mostly upper-case letters, a fair share of lower case, the rest any byte.
	function automatic logic [7:0] pick_code();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			return 8'(CH_UPPER_A + $urandom_range(0, 25));
		end
		if (sel < 17) begin
			return 8'(CH_LOWER_A + $urandom_range(0, 25));
		end
		return 8'($urandom);
	endfunction

	// Queue short text lines near the screen, with some noise: a line that skips
	// its start flag, rows that jump around, starts anywhere in the field range.
	task automatic queue_text_lines(input int count);
		logic signed [9:0] line_x;
		logic signed [8:0] line_y;
		logic signed [8:0] this_y;
		int len;
		int made;
		made = 0;
		while (made < count) begin
			len    = $urandom_range(1, 8);
			line_x = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 250) - 8);
			line_y = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 170) - 8);
			for (int k = 0; k < len && made < count; k++) begin
				this_y = ($urandom_range(0, 9) == 0) ? 9'($urandom) : line_y;
				if (k == 0) begin
					queue_char(pick_code(), $urandom_range(0, 7) != 0, line_x, this_y);
				end else begin
					// start_x is noise here: it only counts on a first character
					queue_char(pick_code(), 1'b0, 10'($urandom), this_y);
				end
				made++;
			end
		end
	endtask

	// Wait until every item is taken and every pixel is in, then let a
	// wholly clipped trailing character finish its scan.
	task automatic wait_quiet();
		while (chars_taken != chars_queued || owed_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Change the text colour; only ever called with the block idle.
	task automatic write_shade(input logic [14:0] value);
		@(posedge clk);
		text_color_we    <= 1'b1;
		text_color_wdata <= value;
		@(posedge clk);
		text_color_we    <= 1'b0;
		pen_shade = value;
	endtask

	initial begin
		arst_n                   = 1'b0;
		text_color_we            = 1'b0;
		text_color_wdata         = '0;
		pen_col                  = '0;
		pen_shade                = SHADE_AT_RESET;
		chars_queued             = 0;
		chars_taken              = 0;
		fails                    = 0;
		cycle_count              = 0;
		send_calm                = 1'b0;
		take_calm                = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset colour, no start flag yet, so the pen begins at column 0.
		queue_char("H", 1'b0, 10'sd0, 9'sd0);
		queue_char("e", 1'b0, 10'sd0, 9'sd0);
		// field extremes; both glyphs land wholly off screen
		queue_char("A", 1'b1, -10'sd512, -9'sd256);
		queue_char("Z", 1'b1, 10'sd511, 9'sd255);
		// partial clipping at the top-left and bottom-right corners
		queue_char("M", 1'b1, -10'sd3, -9'sd3);
		queue_char("W", 1'b1, 10'sd237, 9'sd157);
		// tight against the right and bottom edges, all on screen
		queue_char("Q", 1'b1, 10'sd235, 9'sd153);
		// neighbors of the letter ranges, 0x00 and 0xFF draw nothing but still move the pen; a and z draw
		queue_char(8'h40, 1'b1, 10'sd10, 9'sd10);
		queue_char(8'h5B, 1'b0, 10'sd0, 9'sd10);
		queue_char(8'h60, 1'b0, 10'sd0, 9'sd10);
		queue_char(8'h7B, 1'b0, 10'sd0, 9'sd10);
		queue_char("a", 1'b0, 10'sd0, 9'sd10);
		queue_char("z", 1'b0, 10'sd0, 9'sd10);
		queue_char(8'h00, 1'b0, 10'sd0, 9'sd10);
		queue_char(8'hFF, 1'b0, 10'sd0, 9'sd10);
		// upper half of the byte range is always blank, letter bits or not
		queue_char(8'h80, 1'b1, 10'sd100, 9'sd50);
		queue_char(8'hC1, 1'b0, 10'sd0, 9'sd50);
		queue_char(8'hFA, 1'b0, 10'sd0, 9'sd50);
		queue_char(" ", 1'b0, 10'sd0, 9'sd50);
		// one column short of, and just onto, the left edge
		queue_char("Z", 1'b1, -10'sd5, 9'sd20);
		queue_char("B", 1'b1, -10'sd4, 9'sd20);
		// wholly past the right edge, above the top, below the bottom
		queue_char("K", 1'b1, 10'sd240, 9'sd0);
		queue_char("I", 1'b1, 10'sd0, -9'sd7);
		queue_char("J", 1'b1, 10'sd0, 9'sd160);
		// only the bottom glyph row shows
		queue_char("O", 1'b1, 10'sd0, -9'sd6);
		wait_quiet();

		// Random lines, colour at zero, no idling on either side.
		write_shade(15'h0000);
		send_calm = 1'b1;
		take_calm = 1'b1;
		queue_text_lines(5);
		wait_quiet();

		// Full colour, idling on both sides.
		write_shade(15'h7FFF);
		send_calm = 1'b0;
		take_calm = 1'b0;
		queue_text_lines(5);
		wait_quiet();

		// Long string from the far right: the pen climbs to its ceiling and pins
		// there. Then a fresh line checks drawing resumes.
		write_shade(15'($urandom));
		queue_char("A", 1'b1, 10'sd511, 9'($urandom_range(0, 150)));
		for (int k = 0; k < 74; k++) begin
			queue_char(pick_code(), 1'b0, 10'($urandom), 9'($urandom_range(0, 150)));
		end
		queue_char("R", 1'b1, 10'sd20, 9'sd40);
		queue_char("S", 1'b0, 10'sd0, 9'sd40);
		wait_quiet();

		// Random colour, sender steady, receiver stalling.
		write_shade(15'($urandom));
		send_calm = 1'b1;
		take_calm = 1'b0;
		queue_text_lines(5);
		wait_quiet();

		if (fails == 0 && owed_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
